// File: rtl/tpf_pkg.sv
// Shared types and constants for the point-to-frame transform pipeline.
// Depends on nothing; every other file in rtl imports it.
package tpf_pkg;

    // Unit axes carry this many fraction bits (Q2.30)
    localparam int UNIT_BITS   = 30;
    localparam int SQRT_STEPS  = 32;
    localparam int DIV_STEPS   = 31;
    localparam int CROSS_LAT   = 2;
    localparam int LANE_LAT    = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;
    localparam int MERGE_LAT   = 3;
    localparam int PIPE_LAT    = CROSS_LAT + LANE_LAT + MERGE_LAT;

    typedef logic signed [31:0] q_t;
    typedef logic signed [63:0] wide_t;
    typedef logic signed [32:0] ofs_t;

    typedef struct packed {
        q_t point_x;
        q_t point_y;
        q_t point_z;
        q_t origin_x;
        q_t origin_y;
        q_t origin_z;
        q_t axis1_x;
        q_t axis1_y;
        q_t axis1_z;
        q_t axis2_x;
        q_t axis2_y;
        q_t axis2_z;
    } req_t;

    typedef struct packed {
        q_t local_x;
        q_t local_y;
        q_t local_z;
    } rsp_t;

    typedef struct packed {
        wide_t x;
        wide_t y;
        wide_t z;
    } wvec_t;

    typedef struct packed {
        ofs_t x;
        ofs_t y;
        ofs_t z;
    } dvec_t;

    typedef struct packed {
        q_t x;
        q_t y;
        q_t z;
    } uvec_t;

    // Pipeline control shared by all stages
    typedef struct packed {
        logic adv;
    } pctl_t;

endpackage

// File: rtl/tpf_cross.sv
// Front stages: cross product of the two directions, and the point offset.
// Depends on tpf_pkg.
module tpf_cross (
    input  logic          clk,
    input  tpf_pkg::pctl_t ctl,
    input  tpf_pkg::req_t req,
    output tpf_pkg::wvec_t axis_a,
    output tpf_pkg::wvec_t axis_b,
    output tpf_pkg::wvec_t axis_c,
    output tpf_pkg::dvec_t ofs
);
    import tpf_pkg::*;

    wide_t prod_reg [6];
    wvec_t a1_reg;
    wvec_t b1_reg;
    dvec_t d1_reg;
    wvec_t a2_reg;
    wvec_t b2_reg;
    wvec_t c2_reg;
    dvec_t d2_reg;

    // Stage one: six products, sign-extended directions and the offset
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            prod_reg[0] <= wide_t'(req.axis1_y) * wide_t'(req.axis2_z);
            prod_reg[1] <= wide_t'(req.axis1_z) * wide_t'(req.axis2_y);
            prod_reg[2] <= wide_t'(req.axis1_z) * wide_t'(req.axis2_x);
            prod_reg[3] <= wide_t'(req.axis1_x) * wide_t'(req.axis2_z);
            prod_reg[4] <= wide_t'(req.axis1_x) * wide_t'(req.axis2_y);
            prod_reg[5] <= wide_t'(req.axis1_y) * wide_t'(req.axis2_x);
            a1_reg <= '{wide_t'(req.axis1_x), wide_t'(req.axis1_y), wide_t'(req.axis1_z)};
            b1_reg <= '{wide_t'(req.axis2_x), wide_t'(req.axis2_y), wide_t'(req.axis2_z)};
            d1_reg.x <= ofs_t'(req.point_x) - ofs_t'(req.origin_x);
            d1_reg.y <= ofs_t'(req.point_y) - ofs_t'(req.origin_y);
            d1_reg.z <= ofs_t'(req.point_z) - ofs_t'(req.origin_z);
        end
    end

    // Stage two: differences, wrapping at 64 bits
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            c2_reg.x <= prod_reg[0] - prod_reg[1];
            c2_reg.y <= prod_reg[2] - prod_reg[3];
            c2_reg.z <= prod_reg[4] - prod_reg[5];
            a2_reg   <= a1_reg;
            b2_reg   <= b1_reg;
            d2_reg   <= d1_reg;
        end
    end

    assign axis_a = a2_reg;
    assign axis_b = b2_reg;
    assign axis_c = c2_reg;
    assign ofs    = d2_reg;

endmodule

// File: rtl/tpf_lane.sv
// One normalising lane: scales an axis to unit length in Q2.30.
// Pipelined leading-one search, squares, bit-serial square root and divide.
// Depends on tpf_pkg.
module tpf_lane (
    input  logic           clk,
    input  tpf_pkg::pctl_t ctl,
    input  tpf_pkg::wvec_t axis,
    output tpf_pkg::uvec_t unit
);
    import tpf_pkg::*;

    logic [63:0] comp [3];
    logic [63:0] mag_a_reg [3];
    logic [2:0]  sgn_a_reg;
    logic [63:0] max_a_reg;
    logic [63:0] mag_b_reg [3];
    logic [2:0]  sgn_b_reg;
    logic [7:0]  nz_b_reg;
    logic [2:0]  pos_b_reg [8];
    logic [63:0] mag_c_reg [3];
    logic [2:0]  sgn_c_reg;
    logic [5:0]  msb_c_reg;
    logic        zero_c_reg;
    logic [30:0] m_d_reg [3];
    logic [2:0]  sgn_d_reg;
    logic        zero_d_reg;
    logic [61:0] sq_e_reg [3];
    logic [30:0] m_e_reg [3];
    logic [2:0]  sgn_e_reg;
    logic        zero_e_reg;

    // Square root pipeline, index 0 fed from the sum of squares
    logic [35:0] rt_rem  [SQRT_STEPS+1];
    logic [31:0] rt_root [SQRT_STEPS+1];
    logic [63:0] rt_n    [SQRT_STEPS+1];
    logic [30:0] rt_m    [SQRT_STEPS+1][3];
    logic [2:0]  rt_sgn  [SQRT_STEPS+1];
    logic        rt_zero [SQRT_STEPS+1];

    // Divider pipeline, index 0 fed from the dividend stage
    logic [31:0] dv_rem  [DIV_STEPS+1][3];
    logic [30:0] dv_q    [DIV_STEPS+1][3];
    logic [61:0] dv_num  [DIV_STEPS+1][3];
    logic [31:0] dv_len  [DIV_STEPS+1];
    logic [2:0]  dv_sgn  [DIV_STEPS+1];
    logic        dv_zero [DIV_STEPS+1];

    uvec_t unit_reg;

    function automatic logic [2:0] byte_msb(input logic [7:0] b);
        logic [2:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

    assign comp[0] = axis.x;
    assign comp[1] = axis.y;
    assign comp[2] = axis.z;

    // Magnitudes and their maximum
    always_ff @(posedge clk)
    begin
        logic [63:0] m [3];
        logic [63:0] mx;
        if (ctl.adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m[i] = comp[i][63] ? (64'd0 - comp[i]) : comp[i];
                mag_a_reg[i] <= m[i];
                sgn_a_reg[i] <= comp[i][63];
            end
            mx = (m[0] > m[1]) ? m[0] : m[1];
            max_a_reg <= (mx > m[2]) ? mx : m[2];
        end
    end

    // Leading one inside each byte of the maximum
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int g = 0; g < 8; g++)
            begin
                nz_b_reg[g]  <= |max_a_reg[g*8 +: 8];
                pos_b_reg[g] <= byte_msb(max_a_reg[g*8 +: 8]);
            end
            mag_b_reg <= mag_a_reg;
            sgn_b_reg <= sgn_a_reg;
        end
    end

    // Combine the byte results into one bit position
    always_ff @(posedge clk)
    begin
        logic [5:0] p;
        if (ctl.adv)
        begin
            p = '0;
            for (int g = 0; g < 8; g++)
            begin
                if (nz_b_reg[g])
                begin
                    p = {3'(g), pos_b_reg[g]};
                end
            end
            msb_c_reg  <= p;
            zero_c_reg <= ~|nz_b_reg;
            mag_c_reg  <= mag_b_reg;
            sgn_c_reg  <= sgn_b_reg;
        end
    end

    // Shift all magnitudes so the largest sits in [2^30, 2^31)
    always_ff @(posedge clk)
    begin
        logic [63:0] s;
        if (ctl.adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (msb_c_reg >= 6'd30)
                begin
                    s = mag_c_reg[i] >> (msb_c_reg - 6'd30);
                end
                else
                begin
                    s = mag_c_reg[i] << (6'd30 - msb_c_reg);
                end
                m_d_reg[i] <= s[30:0];
            end
            sgn_d_reg  <= sgn_c_reg;
            zero_d_reg <= zero_c_reg;
        end
    end

    // Squares
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_e_reg[i] <= 62'(m_d_reg[i]) * 62'(m_d_reg[i]);
            end
            m_e_reg    <= m_d_reg;
            sgn_e_reg  <= sgn_d_reg;
            zero_e_reg <= zero_d_reg;
        end
    end

    // Sum of squares feeds the root pipeline
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            rt_n[0]    <= 64'(sq_e_reg[0]) + 64'(sq_e_reg[1]) + 64'(sq_e_reg[2]);
            rt_m[0]    <= m_e_reg;
            rt_sgn[0]  <= sgn_e_reg;
            rt_zero[0] <= zero_e_reg;
        end
    end

    assign rt_rem[0]  = '0;
    assign rt_root[0] = '0;

    // One root bit per stage
    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        always_ff @(posedge clk)
        begin
            logic [35:0] r2;
            logic [35:0] t;
            if (ctl.adv)
            begin
                r2 = {rt_rem[k][33:0], rt_n[k][63:62]};
                t  = {2'b00, rt_root[k], 2'b01};
                if (r2 >= t)
                begin
                    rt_rem[k+1]  <= r2 - t;
                    rt_root[k+1] <= {rt_root[k][30:0], 1'b1};
                end
                else
                begin
                    rt_rem[k+1]  <= r2;
                    rt_root[k+1] <= {rt_root[k][30:0], 1'b0};
                end
                rt_n[k+1]    <= {rt_n[k][61:0], 2'b00};
                rt_m[k+1]    <= rt_m[k];
                rt_sgn[k+1]  <= rt_sgn[k];
                rt_zero[k+1] <= rt_zero[k];
            end
        end
    end

    // Dividend: magnitude scaled to unit bits plus half the length
    always_ff @(posedge clk)
    begin
        logic [61:0] nm;
        if (ctl.adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                nm = (62'(rt_m[SQRT_STEPS][i]) << UNIT_BITS)
                     + 62'(rt_root[SQRT_STEPS] >> 1);
                dv_num[0][i] <= nm;
            end
            dv_len[0]  <= rt_root[SQRT_STEPS];
            dv_sgn[0]  <= rt_sgn[SQRT_STEPS];
            dv_zero[0] <= rt_zero[SQRT_STEPS];
        end
    end

    for (genvar i = 0; i < 3; i++)
    begin : g_dinit
        assign dv_rem[0][i] = {1'b0, dv_num[0][i][61:31]};
        assign dv_q[0][i]   = '0;
    end

    // One quotient bit per stage, three dividers side by side
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        always_ff @(posedge clk)
        begin
            logic [32:0] r2;
            if (ctl.adv)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    r2 = {dv_rem[j][i], dv_num[j][i][DIV_STEPS-1-j]};
                    if (r2 >= {1'b0, dv_len[j]})
                    begin
                        dv_rem[j+1][i] <= 32'(r2 - {1'b0, dv_len[j]});
                        dv_q[j+1][i]   <= {dv_q[j][i][29:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem[j+1][i] <= r2[31:0];
                        dv_q[j+1][i]   <= {dv_q[j][i][29:0], 1'b0};
                    end
                    dv_num[j+1][i] <= dv_num[j][i];
                end
                dv_len[j+1]  <= dv_len[j];
                dv_sgn[j+1]  <= dv_sgn[j];
                dv_zero[j+1] <= dv_zero[j];
            end
        end
    end

    // Restore signs; a zero axis stays zero
    always_ff @(posedge clk)
    begin
        q_t u [3];
        if (ctl.adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (dv_zero[DIV_STEPS])
                begin
                    u[i] = '0;
                end
                else if (dv_sgn[DIV_STEPS][i])
                begin
                    u[i] = 32'd0 - {1'b0, dv_q[DIV_STEPS][i]};
                end
                else
                begin
                    u[i] = {1'b0, dv_q[DIV_STEPS][i]};
                end
            end
            unit_reg <= '{u[0], u[1], u[2]};
        end
    end

    assign unit = unit_reg;

endmodule

// File: rtl/tpf_merge.sv
// Merge stage: projects the offset on the three unit axes from the lanes,
// rounds to Q16.16 and saturates. Depends on tpf_pkg.
module tpf_merge (
    input  logic           clk,
    input  tpf_pkg::pctl_t ctl,
    input  tpf_pkg::dvec_t ofs,
    input  tpf_pkg::uvec_t unit_a,
    input  tpf_pkg::uvec_t unit_b,
    input  tpf_pkg::uvec_t unit_c,
    output tpf_pkg::rsp_t  res
);
    import tpf_pkg::*;

    localparam wide_t HALF   = wide_t'(64'd1 << (UNIT_BITS - 1));
    localparam wide_t SAT_HI = 64'sd2147483647;
    localparam wide_t SAT_LO = -64'sd2147483648;

    ofs_t  d [3];
    q_t    u [3][3];
    wide_t prod_reg [3][3];
    wide_t acc_reg [3];
    q_t    out_reg [3];

    assign d[0] = ofs.x;
    assign d[1] = ofs.y;
    assign d[2] = ofs.z;
    assign u[0] = '{unit_a.x, unit_a.y, unit_a.z};
    assign u[1] = '{unit_b.x, unit_b.y, unit_b.z};
    assign u[2] = '{unit_c.x, unit_c.y, unit_c.z};

    // Nine products
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prod_reg[a][i] <= wide_t'(d[i]) * wide_t'(u[a][i]);
                end
            end
        end
    end

    // Dot products
    always_ff @(posedge clk)
    begin
        if (ctl.adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= prod_reg[a][0] + prod_reg[a][1] + prod_reg[a][2];
            end
        end
    end

    // Round half up, drop unit bits, saturate
    always_ff @(posedge clk)
    begin
        wide_t v;
        if (ctl.adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                v = (acc_reg[a] + HALF) >>> UNIT_BITS;
                if (v > SAT_HI)
                begin
                    out_reg[a] <= SAT_HI[31:0];
                end
                else if (v < SAT_LO)
                begin
                    out_reg[a] <= SAT_LO[31:0];
                end
                else
                begin
                    out_reg[a] <= v[31:0];
                end
            end
        end
    end

    assign res.local_x = out_reg[0];
    assign res.local_y = out_reg[1];
    assign res.local_z = out_reg[2];

endmodule

// File: rtl/transform_point_to_frame_top.sv
// Top level: point into an orthonormal frame, three normalising lanes.
// Depends on tpf_pkg, tpf_cross, tpf_lane and tpf_merge.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-----------------------------
//  input   | req_valid | req_stall | req_data (tpf_pkg::req_t)
//  output  | rsp_valid | rsp_stall | rsp_data (tpf_pkg::rsp_t)
//
// One point per cycle while req_stall is low; each result passes the cross stages,
// the 32-step root and 31-step divider in each lane, the merge and the output register.
// Reset clears the valid bits and the output and skid flags only.
// A stalled result waits in the output register while the next one lands in
// a skid register; only with the skid full does the pipeline freeze and
// req_stall rise.
module transform_point_to_frame_top (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  tpf_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output tpf_pkg::rsp_t  rsp_data
);
    import tpf_pkg::*;

    pctl_t ctl;
    logic  in_xfer;
    logic  out_xfer;
    logic  pipe_exit;
    logic [PIPE_LAT-1:0] vld_reg;
    logic  skid_full_reg;
    logic  rsp_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  skid_reg;
    wvec_t axis_a;
    wvec_t axis_b;
    wvec_t axis_c;
    dvec_t ofs;
    dvec_t ofs_dly [LANE_LAT+1];
    uvec_t unit_a;
    uvec_t unit_b;
    uvec_t unit_c;
    rsp_t  res;

    assign ctl.adv   = ~skid_full_reg;
    assign req_stall = skid_full_reg;
    assign in_xfer   = req_valid & ~skid_full_reg;
    assign out_xfer  = rsp_valid_reg & ~rsp_stall;
    assign pipe_exit = ctl.adv & vld_reg[PIPE_LAT-1];

    // Advance the valid bits with the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (ctl.adv)
        begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], in_xfer};
        end
    end

    tpf_cross u_cross (
        .clk    (clk),
        .ctl    (ctl),
        .req    (req_data),
        .axis_a (axis_a),
        .axis_b (axis_b),
        .axis_c (axis_c),
        .ofs    (ofs)
    );

    tpf_lane u_lane_a (.clk(clk), .ctl(ctl), .axis(axis_a), .unit(unit_a));
    tpf_lane u_lane_b (.clk(clk), .ctl(ctl), .axis(axis_b), .unit(unit_b));
    tpf_lane u_lane_c (.clk(clk), .ctl(ctl), .axis(axis_c), .unit(unit_c));

    // Hold the offset alongside the lanes
    assign ofs_dly[0] = ofs;
    for (genvar k = 0; k < LANE_LAT; k++)
    begin : g_ofs
        always_ff @(posedge clk)
        begin
            if (ctl.adv)
            begin
                ofs_dly[k+1] <= ofs_dly[k];
            end
        end
    end

    tpf_merge u_merge (
        .clk    (clk),
        .ctl    (ctl),
        .ofs    (ofs_dly[LANE_LAT]),
        .unit_a (unit_a),
        .unit_b (unit_b),
        .unit_c (unit_c),
        .res    (res)
    );

    // Output register with skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else if (skid_full_reg)
        begin
            if (out_xfer)
            begin
                skid_full_reg <= 1'b0;
            end
        end
        else if (pipe_exit)
        begin
            if (rsp_valid_reg & rsp_stall)
            begin
                skid_full_reg <= 1'b1;
            end
            else
            begin
                rsp_valid_reg <= 1'b1;
            end
        end
        else if (out_xfer)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_full_reg)
        begin
            if (out_xfer)
            begin
                rsp_reg <= skid_reg;
            end
        end
        else if (pipe_exit)
        begin
            if (rsp_valid_reg & rsp_stall)
            begin
                skid_reg <= res;
            end
            else
            begin
                rsp_reg <= res;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef ASSERT_OFF
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> rsp_valid_reg)
        else $error("skid full without a waiting result");
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(rsp_valid_reg && rsp_stall && pipe_exit))
        else $error("skid filled without a stalled result");
    a_no_exit_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg |-> !pipe_exit)
        else $error("pipeline advanced with skid full");
`endif

endmodule

// File: sim/tb.sv
// Testbench for transform_point_to_frame_top: drives random and edge-case points
// through the pipeline and checks each result against a predictor of the frame maths.
// Depends on tpf_pkg and the RTL under rtl.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import tpf_pkg::*;

    localparam int LAT        = PIPE_LAT + 1;
    localparam int WDOG_LIMIT = 20000;
    localparam int N_RANDOM   = 450;

    // Predictor of the change of basis, kept as wide integer arithmetic
    class frame_board;
        rsp_t pending[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function logic [63:0] isqrt(logic [127:0] n);
            logic [127:0] root;
            logic [127:0] bitv;
            root = 0;
            bitv = 128'd1 << 126;
            while (bitv > n)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n    = n - (root + bitv);
                    root = (root >> 1) + bitv;
                end
                else
                    root = root >> 1;
                bitv >>= 2;
            end
            return root[63:0];
        endfunction

        // Normalise one axis to Q2.30 with a common shift of all magnitudes
        function void unit_of(input logic signed [66:0] c[3], output logic signed [66:0] u[3]);
            logic [66:0]  m[3];
            logic [66:0]  mm;
            logic [127:0] len2;
            logic [63:0]  len;
            logic [127:0] q;
            mm = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = c[i] < 0 ? -c[i] : c[i];
                if (m[i] > mm)
                    mm = m[i];
            end
            if (mm == 0)
            begin
                for (int i = 0; i < 3; i++)
                    u[i] = 0;
                return;
            end
            while (mm > 67'h7FFF_FFFF)
            begin
                for (int i = 0; i < 3; i++)
                    m[i] >>= 1;
                mm >>= 1;
            end
            while (mm < 67'h4000_0000)
            begin
                for (int i = 0; i < 3; i++)
                    m[i] <<= 1;
                mm <<= 1;
            end
            len2 = 0;
            for (int i = 0; i < 3; i++)
                len2 += 128'(m[i]) * 128'(m[i]);
            len = isqrt(len2);
            for (int i = 0; i < 3; i++)
            begin
                q    = ((128'(m[i]) << UNIT_BITS) + (len >> 1)) / len;
                u[i] = c[i] < 0 ? -$signed(67'(q)) : $signed(67'(q));
            end
        endfunction

        // Dot product rounded half up to Q16.16 and saturated
        function q_t project(input logic signed [66:0] d[3], input logic signed [66:0] u[3]);
            logic signed [127:0] acc;
            acc = 0;
            for (int i = 0; i < 3; i++)
                acc += 128'(d[i]) * 128'(u[i]);
            acc = (acc + (128'sd1 <<< (UNIT_BITS - 1))) >>> UNIT_BITS;
            if (acc > 128'sh7FFF_FFFF)
                return 32'h7FFF_FFFF;
            if (acc < -128'sh8000_0000)
                return 32'h8000_0000;
            return q_t'(acc);
        endfunction

        function void note_point(req_t r);
            logic signed [66:0] a[3], b[3], c[3], d[3], ua[3], ub[3], uc[3];
            logic signed [127:0] cw;
            rsp_t e;
            a = '{r.axis1_x, r.axis1_y, r.axis1_z};
            b = '{r.axis2_x, r.axis2_y, r.axis2_z};
            d[0] = 67'(r.point_x) - 67'(r.origin_x);
            d[1] = 67'(r.point_y) - 67'(r.origin_y);
            d[2] = 67'(r.point_z) - 67'(r.origin_z);
            // Cross product wraps to 64 bits like the hardware register
            cw = 128'(a[1]) * 128'(b[2]) - 128'(a[2]) * 128'(b[1]);
            c[0] = 67'($signed(cw[63:0]));
            cw = 128'(a[2]) * 128'(b[0]) - 128'(a[0]) * 128'(b[2]);
            c[1] = 67'($signed(cw[63:0]));
            cw = 128'(a[0]) * 128'(b[1]) - 128'(a[1]) * 128'(b[0]);
            c[2] = 67'($signed(cw[63:0]));
            unit_of(a, ua);
            unit_of(b, ub);
            unit_of(c, uc);
            e.local_x = project(d, ua);
            e.local_y = project(d, ub);
            e.local_z = project(d, uc);
            pending.push_back(e);
        endfunction

        function void check_result(rsp_t got);
            rsp_t e;
            if (pending.size() == 0)
            begin
                $error("result with nothing expected: %h", got);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.local_x !== e.local_x)
            begin
                $error("local_x expected %0d actual %0d", e.local_x, got.local_x);
                errors++;
            end
            if (got.local_y !== e.local_y)
            begin
                $error("local_y expected %0d actual %0d", e.local_y, got.local_y);
                errors++;
            end
            if (got.local_z !== e.local_z)
            begin
                $error("local_z expected %0d actual %0d", e.local_z, got.local_z);
                errors++;
            end
        endfunction
    endclass

    logic  clk = 1'b0;
    logic  rst_n = 1'b0;
    logic  req_valid = 1'b0;
    logic  req_stall;
    req_t  req_data = '0;
    logic  rsp_valid;
    logic  rsp_stall = 1'b0;
    rsp_t  rsp_data;

    frame_board board = new();
    bit     calm = 1'b0;
    int     idle_cycles = 0;

    always #5 clk = ~clk;

    transform_point_to_frame_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    function automatic q_t rand_q(int mode);
        case (mode)
            0: return q_t'($urandom);
            1: return q_t'($urandom_range(0, 32'h0008_0000)) - q_t'(32'h0004_0000);
            2: return q_t'($signed($urandom) >>> $urandom_range(0, 31));
            default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        endcase
    endfunction

    function automatic req_t rand_point();
        req_t r;
        int   mode;
        mode = $urandom_range(0, 9) < 4 ? 1 : ($urandom_range(0, 9) < 6 ? 2 : 0);
        r.point_x  = rand_q(mode);
        r.point_y  = rand_q(mode);
        r.point_z  = rand_q(mode);
        r.origin_x = rand_q(mode);
        r.origin_y = rand_q(mode);
        r.origin_z = rand_q(mode);
        r.axis1_x  = rand_q($urandom_range(0, 3));
        r.axis1_y  = rand_q($urandom_range(0, 3));
        r.axis1_z  = rand_q($urandom_range(0, 3));
        // Sometimes make the second axis parallel or zero
        case ($urandom_range(0, 9))
            0: begin r.axis2_x = r.axis1_x; r.axis2_y = r.axis1_y; r.axis2_z = r.axis1_z; end
            1: begin r.axis2_x = -r.axis1_x; r.axis2_y = -r.axis1_y; r.axis2_z = -r.axis1_z; end
            2: begin r.axis2_x = 0; r.axis2_y = 0; r.axis2_z = 0; end
            default:
            begin
                r.axis2_x = rand_q($urandom_range(0, 3));
                r.axis2_y = rand_q($urandom_range(0, 3));
                r.axis2_z = rand_q($urandom_range(0, 3));
            end
        endcase
        if ($urandom_range(0, 15) == 0)
        begin
            r.axis1_x = 0;
            r.axis1_y = 0;
            r.axis1_z = 0;
        end
        return r;
    endfunction

    // Offer one point, with a random gap first outside the calm stretch, and hold it until the transfer
    task automatic send_point(req_t r);
        while (!calm && $urandom_range(0, 99) < 31)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_point(r);
        @(negedge clk);
    endtask

    // Take a transfer on each rising edge and check it
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            board.check_result(rsp_data);
    end

    // Stall the result side at random outside the calm stretch
    always @(negedge clk)
    begin
        rsp_stall <= !calm && ($urandom_range(0, 99) < 31);
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WDOG_LIMIT)
        begin
            $display("transform_point_to_frame_top regression: fail");
            $finish;
        end
    end

    initial
    begin
        req_t r;
        int   waited;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed points: unit frame, extremes, zero and parallel axes
        r = '0;
        r.axis1_x = 32'h0001_0000;
        r.axis2_y = 32'h0001_0000;
        r.point_x = 32'h0003_0000;
        r.point_y = 32'hFFFE_0000;
        r.point_z = 32'h0000_8000;
        send_point(r);
        r.origin_x = 32'h7FFF_FFFF;
        r.point_x  = 32'h8000_0000;
        send_point(r);
        r.origin_x = 32'h8000_0000;
        r.point_x  = 32'h7FFF_FFFF;
        send_point(r);
        r = '0;
        send_point(r);
        r = '1;
        send_point(r);
        r = {12{32'h7FFF_FFFF}};
        send_point(r);
        r = {12{32'h8000_0000}};
        send_point(r);
        r = {6{32'h7FFF_FFFF, 32'h8000_0000}};
        send_point(r);
        r = '0;
        r.point_x = 32'h7FFF_FFFF;
        r.point_y = 32'h7FFF_FFFF;
        r.point_z = 32'h7FFF_FFFF;
        r.origin_x = 32'h8000_0000;
        r.origin_y = 32'h8000_0000;
        r.origin_z = 32'h8000_0000;
        r.axis1_x = 32'h0000_0001;
        r.axis1_y = 32'h0000_0001;
        r.axis1_z = 32'h0000_0001;
        r.axis2_x = 32'h0000_0001;
        r.axis2_y = 32'hFFFF_FFFF;
        send_point(r);
        r.axis2_x = 32'h0000_0002;
        r.axis2_y = 32'h0000_0002;
        r.axis2_z = 32'h0000_0002;
        send_point(r);
        r.axis1_x = 0;
        r.axis1_y = 0;
        r.axis1_z = 0;
        send_point(r);
        r.axis1_x = 32'h8000_0000;
        r.axis1_y = 32'h7FFF_FFFF;
        r.axis2_x = 32'h7FFF_FFFF;
        r.axis2_z = 32'h8000_0000;
        send_point(r);

        // Random points, with a calm stretch in the middle
        for (int i = 0; i < N_RANDOM; i++)
        begin
            calm = (i >= 150 && i < 250);
            send_point(rand_point());
        end
        calm = 1'b0;
        req_valid <= 1'b0;

        // Drain, then wait out the pipeline
        waited = 0;
        while (board.pending.size() != 0 && waited < 200000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (LAT + 10) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("transform_point_to_frame_top regression: pass");
        else
            $display("transform_point_to_frame_top regression: fail");
        $finish;
    end
endmodule
